// File: src/dpwp_pkg.sv
// package for the depth pixel to world point block: constants, types and helpers
`default_nettype none

package dpwp_pkg;

  localparam int IMAGE_COLS = 640;
  localparam int IMAGE_ROWS = 480;
  localparam int SKIP_STEP  = 1;

  localparam int SKIP_SHIFT = 16;
  localparam int SKIP_RECIP = ((1 << SKIP_SHIFT) + SKIP_STEP - 1) / SKIP_STEP;

  localparam logic [3:0] REG_DEPTH_UNIT  = 4'd0;
  localparam logic [3:0] REG_INV_FOCAL_X = 4'd1;
  localparam logic [3:0] REG_INV_FOCAL_Y = 4'd2;
  localparam logic [3:0] REG_CENTER_X    = 4'd3;
  localparam logic [3:0] REG_CENTER_Y    = 4'd4;
  localparam logic [3:0] REG_MIN_DEPTH   = 4'd5;
  localparam logic [3:0] REG_MAX_DEPTH   = 4'd6;
  localparam logic [3:0] REG_EDGE_MARGIN = 4'd7;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_POSE  = 1'b1;

  localparam int POSE_WORDS = 12;

  typedef struct packed {
    logic [23:0] depth_unit;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [13:0] center_x;
    logic [13:0] center_y;
    logic [23:0] min_depth;
    logic [23:0] max_depth;
    logic [5:0]  edge_margin;
  } cfg_t;

  typedef struct packed {
    logic               is_pose;
    logic [3:0]         slot;
    logic [31:0]        value;
    logic [23:0]        depth;
    logic               clamped;
    logic signed [14:0] dx;
    logic signed [14:0] dy;
  } front_item_t;

  typedef struct packed {
    logic               is_pose;
    logic [3:0]         slot;
    logic [31:0]        value;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic [23:0]        depth;
    logic               clamped;
  } cam_item_t;

  // margin window and skip grid test for one coordinate
  function automatic logic on_grid(input logic [9:0] pos, input logic [12:0] size,
                                   input logic [5:0] margin);
    logic [13:0] upper;
    logic [9:0]  offset;
    logic [31:0] prod;
    logic [15:0] quot;
    logic [31:0] back;
    upper  = 14'(pos) + 14'(margin);
    offset = pos - 10'(margin);
    prod   = 32'(offset) * 32'(SKIP_RECIP);
    quot   = prod[31:16];
    back   = 32'(quot) * 32'(SKIP_STEP);
    return (pos >= 10'(margin)) && (upper < 14'(size)) && (back == 32'(offset));
  endfunction

  function automatic logic [31:0] sat37(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// File: src/dpwp_front.sv
// front stages: margin and grid filter, depth scaling, clamp and near drop
`default_nettype none

module dpwp_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dpwp_pkg::cfg_t       cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 op_i,
  input  wire logic [9:0]           col_i,
  input  wire logic [8:0]           row_index_i,
  input  wire logic [15:0]          raw_depth_i,
  input  wire logic [3:0]           pose_slot_i,
  input  wire logic [31:0]          pose_value_i,
  output logic                      out_valid_o,
  output dpwp_pkg::front_item_t     out_item_o,
  input  wire logic                 out_ready_i
);

  logic               s1_valid_q, s1_valid_d;
  logic               s1_pose_q;
  logic [3:0]         s1_slot_q;
  logic [31:0]        s1_value_q;
  logic [39:0]        s1_scaled_q, s1_scaled_d;
  logic               s1_zero_q;
  logic signed [14:0] s1_dx_q, s1_dx_d;
  logic signed [14:0] s1_dy_q, s1_dy_d;

  logic                  s2_valid_q, s2_valid_d;
  dpwp_pkg::front_item_t s2_item_q, s2_item_d;

  logic        en1, en2;
  logic        keep1, col_ok, row_ok;
  logic [40:0] rounded;
  logic [32:0] depth_full;
  logic        clamp, near;

  assign en2        = !s2_valid_q || out_ready_i;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  // stage 1
  always_comb begin
    col_ok = dpwp_pkg::on_grid(col_i, 13'(dpwp_pkg::IMAGE_COLS), cfg_i.edge_margin);
    row_ok = dpwp_pkg::on_grid({1'b0, row_index_i}, 13'(dpwp_pkg::IMAGE_ROWS),
                               cfg_i.edge_margin);
    if (op_i == dpwp_pkg::OP_POSE) begin
      keep1 = pose_slot_i < 4'(dpwp_pkg::POSE_WORDS);
    end else begin
      keep1 = col_ok && row_ok;
    end
    s1_valid_d  = in_valid_i && keep1;
    s1_scaled_d = 40'(raw_depth_i) * 40'(cfg_i.depth_unit);
    s1_dx_d     = $signed({1'b0, col_i, 4'b0000}) - $signed({1'b0, cfg_i.center_x});
    s1_dy_d     = $signed({2'b00, row_index_i, 4'b0000}) - $signed({1'b0, cfg_i.center_y});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_pose_q   <= op_i;
      s1_slot_q   <= pose_slot_i;
      s1_value_q  <= pose_value_i;
      s1_scaled_q <= s1_scaled_d;
      s1_zero_q   <= raw_depth_i == 16'd0;
      s1_dx_q     <= s1_dx_d;
      s1_dy_q     <= s1_dy_d;
    end
  end

  // stage 2
  always_comb begin
    rounded    = 41'(s1_scaled_q) + 41'd128;
    depth_full = rounded[40:8];
    clamp      = s1_zero_q || (depth_full > 33'(cfg_i.max_depth));
    near       = !clamp && (depth_full < 33'(cfg_i.min_depth));
    s2_valid_d = s1_valid_q && (s1_pose_q || !near);
    s2_item_d.is_pose = s1_pose_q;
    s2_item_d.slot    = s1_slot_q;
    s2_item_d.value   = s1_value_q;
    s2_item_d.depth   = clamp ? cfg_i.max_depth : depth_full[23:0];
    s2_item_d.clamped = clamp;
    s2_item_d.dx      = s1_dx_q;
    s2_item_d.dy      = s1_dy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      s2_item_q <= s2_item_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_item_o  = s2_item_q;

endmodule

`default_nettype wire

// File: src/dpwp_proj.sv
// projection stages: offset times depth, reciprocal focal scaling, saturation
`default_nettype none

module dpwp_proj (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dpwp_pkg::cfg_t        cfg_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire dpwp_pkg::front_item_t in_item_i,
  output logic                       out_valid_o,
  output dpwp_pkg::cam_item_t        out_item_o,
  input  wire logic                  out_ready_i
);

  logic               s3_valid_q;
  logic               s3_pose_q;
  logic [3:0]         s3_slot_q;
  logic [31:0]        s3_value_q;
  logic signed [39:0] s3_px_q, s3_px_d;
  logic signed [39:0] s3_py_q, s3_py_d;
  logic [23:0]        s3_depth_q;
  logic               s3_clamp_q;

  logic               s4_valid_q;
  logic               s4_pose_q;
  logic [3:0]         s4_slot_q;
  logic [31:0]        s4_value_q;
  logic signed [60:0] s4_qx_q, s4_qx_d;
  logic signed [60:0] s4_qy_q, s4_qy_d;
  logic [23:0]        s4_depth_q;
  logic               s4_clamp_q;

  logic                s5_valid_q;
  dpwp_pkg::cam_item_t s5_item_q, s5_item_d;

  logic               en3, en4, en5;
  logic signed [39:0] tx_full, ty_full;
  logic signed [35:0] tx, ty;
  logic signed [60:0] rx, ry;

  assign en5        = !s5_valid_q || out_ready_i;
  assign en4        = !s4_valid_q || en5;
  assign en3        = !s3_valid_q || en4;
  assign in_ready_o = en3;

  // stage 3
  always_comb begin
    s3_px_d = 40'($signed(in_item_i.dx)) * 40'($signed({1'b0, in_item_i.depth}));
    s3_py_d = 40'($signed(in_item_i.dy)) * 40'($signed({1'b0, in_item_i.depth}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en3) begin
      s3_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && in_valid_i) begin
      s3_pose_q  <= in_item_i.is_pose;
      s3_slot_q  <= in_item_i.slot;
      s3_value_q <= in_item_i.value;
      s3_px_q    <= s3_px_d;
      s3_py_q    <= s3_py_d;
      s3_depth_q <= in_item_i.depth;
      s3_clamp_q <= in_item_i.clamped;
    end
  end

  // stage 4
  always_comb begin
    tx_full = (s3_px_q + 40'sd8) >>> 4;
    ty_full = (s3_py_q + 40'sd8) >>> 4;
    tx      = tx_full[35:0];
    ty      = ty_full[35:0];
    s4_qx_d = 61'(tx) * 61'($signed({1'b0, cfg_i.inv_focal_x}));
    s4_qy_d = 61'(ty) * 61'($signed({1'b0, cfg_i.inv_focal_y}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en4) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && s3_valid_q) begin
      s4_pose_q  <= s3_pose_q;
      s4_slot_q  <= s3_slot_q;
      s4_value_q <= s3_value_q;
      s4_qx_q    <= s4_qx_d;
      s4_qy_q    <= s4_qy_d;
      s4_depth_q <= s3_depth_q;
      s4_clamp_q <= s3_clamp_q;
    end
  end

  // stage 5
  always_comb begin
    rx = s4_qx_q + 61'sd8388608;
    ry = s4_qy_q + 61'sd8388608;
    s5_item_d.is_pose = s4_pose_q;
    s5_item_d.slot    = s4_slot_q;
    s5_item_d.value   = s4_value_q;
    s5_item_d.cam_x   = dpwp_pkg::sat37(rx[60:24]);
    s5_item_d.cam_y   = dpwp_pkg::sat37(ry[60:24]);
    s5_item_d.depth   = s4_depth_q;
    s5_item_d.clamped = s4_clamp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en5) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && s4_valid_q) begin
      s5_item_q <= s5_item_d;
    end
  end

  assign out_valid_o = s5_valid_q;
  assign out_item_o  = s5_item_q;

endmodule

`default_nettype wire

// File: src/dpwp_xform.sv
// pose store and rigid transform stages: rotation products, sums, rounding
`default_nettype none

module dpwp_xform (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dpwp_pkg::cam_item_t in_item_i,
  output logic                     out_valid_o,
  output logic [31:0]              world_x_o,
  output logic [31:0]              world_y_o,
  output logic [31:0]              world_z_o,
  output logic                     depth_clamped_o,
  input  wire logic                out_ready_i
);

  logic signed [31:0] pose_q [dpwp_pkg::POSE_WORDS];

  logic               s6_valid_q, s6_valid_d;
  logic signed [63:0] s6_prod_q [9];
  logic signed [63:0] s6_prod_d [9];
  logic signed [31:0] s6_pos_q [3];
  logic               s6_clamp_q;

  logic               s7_valid_q;
  logic signed [66:0] s7_sum_q [3];
  logic signed [66:0] s7_sum_d [3];
  logic               s7_clamp_q;

  logic               s8_valid_q;
  logic [31:0]        s8_world_q [3];
  logic [31:0]        s8_world_d [3];
  logic               s8_clamp_q;

  logic               en6, en7, en8;
  logic               pose_wr;
  logic signed [31:0] cam [3];

  assign en8        = !s8_valid_q || out_ready_i;
  assign en7        = !s7_valid_q || en8;
  assign en6        = !s6_valid_q || en7;
  assign in_ready_o = en6;

  // pose words are written in stream order, so earlier pixels keep the old pose
  assign pose_wr = in_valid_i && en6 && in_item_i.is_pose;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < dpwp_pkg::POSE_WORDS; k++) begin
        pose_q[k] <= 32'sd0;
      end
    end else if (pose_wr) begin
      for (int k = 0; k < dpwp_pkg::POSE_WORDS; k++) begin
        if (in_item_i.slot == 4'(k)) begin
          pose_q[k] <= in_item_i.value;
        end
      end
    end
  end

  // stage 6
  always_comb begin
    cam[0] = in_item_i.cam_x;
    cam[1] = in_item_i.cam_y;
    cam[2] = $signed({8'b0, in_item_i.depth});
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s6_prod_d[i*3+j] = 64'(pose_q[i*3+j]) * 64'(cam[j]);
      end
    end
    s6_valid_d = in_valid_i && !in_item_i.is_pose;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (en6) begin
      s6_valid_q <= s6_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6 && s6_valid_d) begin
      for (int k = 0; k < 9; k++) begin
        s6_prod_q[k] <= s6_prod_d[k];
      end
      for (int i = 0; i < 3; i++) begin
        s6_pos_q[i] <= pose_q[9+i];
      end
      s6_clamp_q <= in_item_i.clamped;
    end
  end

  // stage 7: exact sum with position and rounding half folded in
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s7_sum_d[i] = 67'(s6_prod_q[i*3]) + 67'(s6_prod_q[i*3+1]) + 67'(s6_prod_q[i*3+2])
                  + 67'($signed({s6_pos_q[i], 30'b0})) + 67'sd536870912;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else if (en7) begin
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en7 && s6_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        s7_sum_q[i] <= s7_sum_d[i];
      end
      s7_clamp_q <= s6_clamp_q;
    end
  end

  // stage 8: scale down and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s8_world_d[i] = dpwp_pkg::sat37(s7_sum_q[i][66:30]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_valid_q <= 1'b0;
    end else if (en8) begin
      s8_valid_q <= s7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en8 && s7_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        s8_world_q[i] <= s8_world_d[i];
      end
      s8_clamp_q <= s7_clamp_q;
    end
  end

  assign out_valid_o     = s8_valid_q;
  assign world_x_o       = s8_world_q[0];
  assign world_y_o       = s8_world_q[1];
  assign world_z_o       = s8_world_q[2];
  assign depth_clamped_o = s8_clamp_q;

endmodule

`default_nettype wire

// File: src/depth_pixel_to_world_point.sv
// top level: depth pixel back-projection into the world frame
//
// input channel (in_valid_i / in_stall_o): op_i selects a depth pixel or a
// pose word load. a pose load writes one of twelve pose words (rotation
// row-major, then position) and gives no result; it takes effect for every
// pixel accepted after it. pixels off the margin window or skip grid, and
// pixels nearer than min_depth, give no result. every other pixel gives one
// transaction on the output channel (out_valid_o / out_stall_i).
// an 8-stage pipeline: each result passes stage registers s1 to s8 in order
// before it is presented, and one item is accepted every cycle while the output
// moves. the stages close up bubbles, so a stalled output still lets new items
// enter until the pipeline is full; the per-stage advance chain sets this.
// configuration writes (cfg_valid_i, cfg_index_i, cfg_data_i) are taken every
// cycle and must only happen while the pipeline is empty.
// reset empties the pipeline, zeroes the pose and loads the default
// configuration; no clearing pass is needed.
`default_nettype none

module depth_pixel_to_world_point (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [9:0]  col_i,
  input  wire logic [8:0]  row_index_i,
  input  wire logic [15:0] raw_depth_i,
  input  wire logic [3:0]  pose_slot_i,
  input  wire logic [31:0] pose_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      world_x_o,
  output logic [31:0]      world_y_o,
  output logic [31:0]      world_z_o,
  output logic             depth_clamped_o
);

  dpwp_pkg::cfg_t        cfg_q;
  dpwp_pkg::front_item_t front_item;
  dpwp_pkg::cam_item_t   cam_item;
  logic                  front_valid, front_ready;
  logic                  cam_valid, cam_ready;
  logic                  in_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_unit  <= 24'd16777;
      cfg_q.inv_focal_x <= 24'd43691;
      cfg_q.inv_focal_y <= 24'd43691;
      cfg_q.center_x    <= 14'd5120;
      cfg_q.center_y    <= 14'd3840;
      cfg_q.min_depth   <= 24'd6554;
      cfg_q.max_depth   <= 24'd327680;
      cfg_q.edge_margin <= 6'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dpwp_pkg::REG_DEPTH_UNIT:  cfg_q.depth_unit  <= cfg_data_i;
        dpwp_pkg::REG_INV_FOCAL_X: cfg_q.inv_focal_x <= cfg_data_i;
        dpwp_pkg::REG_INV_FOCAL_Y: cfg_q.inv_focal_y <= cfg_data_i;
        dpwp_pkg::REG_CENTER_X:    cfg_q.center_x    <= cfg_data_i[13:0];
        dpwp_pkg::REG_CENTER_Y:    cfg_q.center_y    <= cfg_data_i[13:0];
        dpwp_pkg::REG_MIN_DEPTH:   cfg_q.min_depth   <= cfg_data_i;
        dpwp_pkg::REG_MAX_DEPTH:   cfg_q.max_depth   <= cfg_data_i;
        dpwp_pkg::REG_EDGE_MARGIN: cfg_q.edge_margin <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  dpwp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready),
    .op_i         (op_i),
    .col_i        (col_i),
    .row_index_i  (row_index_i),
    .raw_depth_i  (raw_depth_i),
    .pose_slot_i  (pose_slot_i),
    .pose_value_i (pose_value_i),
    .out_valid_o  (front_valid),
    .out_item_o   (front_item),
    .out_ready_i  (front_ready)
  );

  dpwp_proj u_proj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_item_i   (front_item),
    .out_valid_o (cam_valid),
    .out_item_o  (cam_item),
    .out_ready_i (cam_ready)
  );

  dpwp_xform u_xform (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (cam_valid),
    .in_ready_o      (cam_ready),
    .in_item_i       (cam_item),
    .out_valid_o     (out_valid_o),
    .world_x_o       (world_x_o),
    .world_y_o       (world_y_o),
    .world_z_o       (world_z_o),
    .depth_clamped_o (depth_clamped_o),
    .out_ready_i     (!out_stall_i)
  );

  assign in_stall_o = !in_ready;

endmodule

`default_nettype wire

// File: verif/dpwp_checker.sv
`timescale 1ns / 1ps
// checker for the depth pixel to world point block: predicts world points and compares results
module dpwp_checker
  import dpwp_pkg::*;
#(
  parameter cfg_t RESET_CFG = '0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        op_i,
  input  logic [9:0]  col_i,
  input  logic [8:0]  row_index_i,
  input  logic [15:0] raw_depth_i,
  input  logic [3:0]  pose_slot_i,
  input  logic [31:0] pose_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] world_x_i,
  input  logic [31:0] world_y_i,
  input  logic [31:0] world_z_i,
  input  logic        depth_clamped_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        clamped;
  } world_point_t;

  cfg_t               cam_cfg;
  logic signed [31:0] pose_word [POSE_WORDS];
  world_point_t       point_q [$];
  int                 mismatches;

  function automatic logic [31:0] saturate_word(input wide_t v);
    if (v > wide_t'(32'sh7FFF_FFFF)) begin
      return 32'h7FFF_FFFF;
    end else if (v < wide_t'(32'sh8000_0000)) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic in_window(input longint pos, input longint size, input longint margin);
    return (pos >= margin) && (pos < size - margin) && ((pos - margin) % SKIP_STEP == 0);
  endfunction

  // back-projects one pixel; returns 0 when the pixel gives no point
  function automatic logic project_pixel(input logic [9:0] col, input logic [8:0] row,
                                         input logic [15:0] raw, output world_point_t pt);
    longint      depth;
    longint      dx;
    longint      dy;
    longint      tx;
    longint      ty;
    wide_t       cam [3];
    wide_t       acc;
    logic        clamped;
    logic [31:0] w [3];
    pt = '0;
    if (!in_window(longint'(col), IMAGE_COLS, longint'(cam_cfg.edge_margin)) ||
        !in_window(longint'(row), IMAGE_ROWS, longint'(cam_cfg.edge_margin))) begin
      return 1'b0;
    end
    depth   = (longint'(raw) * longint'(cam_cfg.depth_unit) + 128) >>> 8;
    clamped = 1'b0;
    if (raw == 16'd0 || depth > longint'(cam_cfg.max_depth)) begin
      depth   = longint'(cam_cfg.max_depth);
      clamped = 1'b1;
    end else if (depth < longint'(cam_cfg.min_depth)) begin
      return 1'b0;
    end
    dx = longint'(col) * 16 - longint'(cam_cfg.center_x);
    dy = longint'(row) * 16 - longint'(cam_cfg.center_y);
    tx = (dx * depth + 8) >>> 4;
    ty = (dy * depth + 8) >>> 4;
    cam[0] = wide_t'($signed(saturate_word(
               wide_t'((tx * longint'(cam_cfg.inv_focal_x) + 64'sd8388608) >>> 24))));
    cam[1] = wide_t'($signed(saturate_word(
               wide_t'((ty * longint'(cam_cfg.inv_focal_y) + 64'sd8388608) >>> 24))));
    cam[2] = wide_t'(depth);
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        acc += wide_t'(pose_word[i * 3 + j]) * cam[j];
      end
      acc  = (acc + (wide_t'(1) <<< 29)) >>> 30;
      acc += wide_t'(pose_word[9 + i]);
      w[i] = saturate_word(acc);
    end
    pt = '{x: w[0], y: w[1], z: w[2], clamped: clamped};
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    world_point_t pt;
    world_point_t got;
    if (!rst_ni) begin
      cam_cfg = RESET_CFG;
      foreach (pose_word[k]) begin
        pose_word[k] = '0;
      end
      point_q.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DEPTH_UNIT:  cam_cfg.depth_unit  = cfg_data_i;
          REG_INV_FOCAL_X: cam_cfg.inv_focal_x = cfg_data_i;
          REG_INV_FOCAL_Y: cam_cfg.inv_focal_y = cfg_data_i;
          REG_CENTER_X:    cam_cfg.center_x    = cfg_data_i[13:0];
          REG_CENTER_Y:    cam_cfg.center_y    = cfg_data_i[13:0];
          REG_MIN_DEPTH:   cam_cfg.min_depth   = cfg_data_i;
          REG_MAX_DEPTH:   cam_cfg.max_depth   = cfg_data_i;
          REG_EDGE_MARGIN: cam_cfg.edge_margin = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_POSE) begin
          if (pose_slot_i < POSE_WORDS) begin
            pose_word[pose_slot_i] = pose_value_i;
          end
        end else if (project_pixel(col_i, row_index_i, raw_depth_i, pt)) begin
          point_q = {point_q, pt};
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{x: world_x_i, y: world_y_i, z: world_z_i, clamped: depth_clamped_i};
        if (point_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected transaction: x=%0d y=%0d z=%0d clamped=%0b",
                     $signed(got.x), $signed(got.y), $signed(got.z), got.clamped);
          end
          mismatches++;
        end else begin
          pt = point_q.pop_front();
          if (pt.x !== got.x || pt.y !== got.y || pt.z !== got.z ||
              pt.clamped !== got.clamped) begin
            if (mismatches < 10) begin
              $display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                       $signed(pt.x), $signed(pt.y), $signed(pt.z), pt.clamped,
                       $signed(got.x), $signed(got.y), $signed(got.z), got.clamped);
            end
            mismatches++;
          end
        end
      end
      pending_o    <= point_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the depth pixel to world point block: stimulus, idling and verdict
module tb_top;
  import dpwp_pkg::*;

  localparam cfg_t RESET_CFG = '{depth_unit: 24'd16777, inv_focal_x: 24'd43691,
                                 inv_focal_y: 24'd43691, center_x: 14'd5120,
                                 center_y: 14'd3840, min_depth: 24'd6554,
                                 max_depth: 24'd327680, edge_margin: 6'd0};
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 6;
  localparam int RANDOM_ITEMS   = 150;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 300;
  localparam logic [3:0] REG_SPARE = 4'd15;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i  = '0;
  logic [23:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic        op_i         = OP_PIXEL;
  logic [9:0]  col_i        = '0;
  logic [8:0]  row_index_i  = '0;
  logic [15:0] raw_depth_i  = '0;
  logic [3:0]  pose_slot_i  = '0;
  logic [31:0] pose_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [31:0] world_x_o;
  logic [31:0] world_y_o;
  logic [31:0] world_z_o;
  logic        depth_clamped_o;

  int   pending;
  int   fail_count;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_reqs     = 0;
  int   stuck_cycles  = 0;
  cfg_t cur_cfg       = RESET_CFG;

  depth_pixel_to_world_point i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .op_i, .col_i, .row_index_i, .raw_depth_i,
    .pose_slot_i, .pose_value_i, .out_valid_o, .out_stall_i,
    .world_x_o, .world_y_o, .world_z_o, .depth_clamped_o
  );

  dpwp_checker #(.RESET_CFG(RESET_CFG)) i_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .op_i, .col_i, .row_index_i, .raw_depth_i,
    .pose_slot_i, .pose_value_i, .out_valid_i(out_valid_o), .out_stall_i,
    .world_x_i(world_x_o), .world_y_i(world_y_o), .world_z_i(world_z_o),
    .depth_clamped_i(depth_clamped_o), .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [3:0] index, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_DEPTH_UNIT, c.depth_unit);
    write_reg(REG_INV_FOCAL_X, c.inv_focal_x);
    write_reg(REG_INV_FOCAL_Y, c.inv_focal_y);
    write_reg(REG_CENTER_X, 24'(c.center_x));
    write_reg(REG_CENTER_Y, 24'(c.center_y));
    write_reg(REG_MIN_DEPTH, c.min_depth);
    write_reg(REG_MAX_DEPTH, c.max_depth);
    write_reg(REG_EDGE_MARGIN, 24'(c.edge_margin));
    write_reg(REG_SPARE, 24'($urandom));
    cfg_valid_i <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic push_item(input logic op, input logic [9:0] col, input logic [8:0] row,
                           input logic [15:0] raw, input logic [3:0] slot,
                           input logic [31:0] value);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    col_i        <= col;
    row_index_i  <= row;
    raw_depth_i  <= raw;
    pose_slot_i  <= slot;
    pose_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic push_pixel(input int col, input int row, input int raw);
    push_item(OP_PIXEL, 10'(col), 9'(row), 16'(raw), 4'($urandom), $urandom);
  endtask

  task automatic push_pose(input int slot, input logic [31:0] value);
    push_item(OP_POSE, 10'($urandom), 9'($urandom), 16'($urandom), 4'(slot), value);
  endtask

  // raw depth that lands between the near and far limits where possible
  function automatic int pick_raw();
    longint lo;
    longint hi;
    if (cur_cfg.depth_unit == 0) begin
      return $urandom_range(1, 65535);
    end
    lo = (longint'(cur_cfg.min_depth) * 256) / longint'(cur_cfg.depth_unit);
    hi = (longint'(cur_cfg.max_depth) * 256) / longint'(cur_cfg.depth_unit) + 1;
    lo = (lo < 1) ? 1 : (lo > 65535) ? 65535 : lo;
    hi = (hi < 1) ? 1 : (hi > 65535) ? 65535 : hi;
    return $urandom_range(int'(lo), int'(hi));
  endfunction

  task automatic random_item();
    int          pick;
    int          slot;
    int          margin;
    logic [31:0] value;
    pick   = $urandom_range(0, 99);
    margin = cur_cfg.edge_margin;
    if (pick < 8) begin
      slot = $urandom_range(0, 15);
      if ($urandom_range(0, 2) == 0) begin
        value = $urandom;
      end else if (slot < 9) begin
        value = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      end else begin
        value = $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
      end
      push_pose(slot, value);
    end else if (pick < 20) begin
      push_pixel($urandom_range(0, 1023), $urandom_range(0, 511), $urandom_range(0, 65535));
    end else begin
      push_pixel($urandom_range(margin, IMAGE_COLS - 1 - margin),
                 $urandom_range(margin, IMAGE_ROWS - 1 - margin),
                 ($urandom_range(0, 19) == 0) ? 0 : pick_raw());
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic cfg_t config_for(input int phase);
    case (phase)
      2: return '{depth_unit: '1, inv_focal_x: '1, inv_focal_y: '1, center_x: '1,
                  center_y: '1, min_depth: '0, max_depth: '1, edge_margin: '1};
      3: return '0;
      4: return '{depth_unit: 24'd16777, inv_focal_x: 24'd43691, inv_focal_y: 24'd43691,
                  center_x: 14'd5120, center_y: 14'd3840, min_depth: 24'd500000,
                  max_depth: 24'd200000, edge_margin: 6'd5};
      default: return '{depth_unit: 24'($urandom_range(4000, 70000)),
                        inv_focal_x: 24'($urandom_range(10000, 100000)),
                        inv_focal_y: 24'($urandom_range(10000, 100000)),
                        center_x: 14'($urandom), center_y: 14'($urandom),
                        min_depth: 24'($urandom_range(0, 20000)),
                        max_depth: 24'($urandom_range(100000, 2000000)),
                        edge_margin: 6'($urandom)};
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 78;
        end
        default: begin
          send_idle_pct = 12;
          recv_idle_pct = 12;
        end
      endcase
      if (phase != 0) begin
        apply_config(config_for(phase));
      end else begin
        // zero pose first, then identity rotation with an offset position
        push_pixel(320, 240, 1000);
        for (int s = 0; s < 9; s++) begin
          push_pose(s, (s % 4 == 0) ? 32'h4000_0000 : 32'h0);
        end
        push_pose(9, 32'h0001_8000);
        push_pose(10, 32'hFFFE_0000);
        push_pose(11, 32'h0000_4000);
        push_pose(12, 32'hFFFF_FFFF);
        push_pixel(0, 0, 65535);
        push_pixel(639, 479, 0);
        push_pixel(320, 240, 1000);
        push_pixel(100, 50, 50);
        push_pixel(640, 10, 1000);
        push_pixel(10, 480, 1000);
        push_pixel(1023, 511, 65535);
        push_pixel(0, 479, 1);
        hold_reqs++;
      end
      repeat (RANDOM_ITEMS) random_item();
      drain();
    end
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
src/dpwp_pkg.sv
src/dpwp_front.sv
src/dpwp_proj.sv
src/dpwp_xform.sv
src/depth_pixel_to_world_point.sv
verif/dpwp_checker.sv
verif/tb_top.sv
